/* rtl/assert_macros.svh */
// assertion macros used by the directory rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on clk_i, off while rst_ni is low
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on every rising clk_i edge
`define ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

`endif

/* rtl/hlbd_pkg.sv */
// shared constants and codes of the buffer directory
`timescale 1ns / 1ps
package hlbd_pkg;

  localparam int EntriesDef = 32;
  localparam int BucketsDef = 13;
  localparam int BlockW     = 32;
  localparam int DeviceW    = 32;
  localparam int StampW     = 32;
  localparam int RefW       = 8;
  localparam int BufIdxW    = 5;

  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFREE  = 2'd1,
    ST_REFUSED = 2'd2
  } status_e;

endpackage

/* rtl/hashed_lru_block_buffer_directory.sv */
// Directory of a hashed LRU disk block buffer cache. One request is handled at a
// time. A get first forms the home bucket (block number modulo BUCKETS, by a
// multiply with the rounded-up reciprocal and a multiply-back), then starts the
// sweep and sweeps the entry memory through its single read port, looking for a
// match and the nearest least recent free entry, and ends in an update cycle
// that loads the result register; the next request is taken once the block is
// back in idle. Release, pin and unpin read the entry once and write it back. A
// result that is not taken holds the block in its update cycle. Entries not yet
// written read as their reset contents through per-entry written flags, so no
// clearing pass is needed.
`timescale 1ns / 1ps
module hashed_lru_block_buffer_directory import hlbd_pkg::*; #(
  parameter int ENTRIES = EntriesDef,
  parameter int BUCKETS = BucketsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // device [31:0], block_number [63:32], buffer_index [68:64], zero fill
  input  logic [71:0] s_axis_tdata_i,
  // opcode [1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // entry_index [4:0], hit [5], needs_read [6], status [8:7], zero fill
  output logic [15:0] m_axis_tdata_o
);

`include "assert_macros.svh"

  localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int BKW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  typedef struct packed {
    logic [StampW-1:0]  stamp;
    logic [BKW-1:0]     bucket;
    logic               valid;
    logic [RefW-1:0]    refcnt;
    logic [BlockW-1:0]  blk;
    logic [DeviceW-1:0] dev;
  } entry_t;

  typedef enum logic [1:0] {S_IDLE, S_MOD, S_SCAN, S_UPD} state_e;

  state_e state_q;

  // entry memory and written flags
  entry_t            mem_q [ENTRIES];
  logic [ENTRIES-1:0] wr_q;
  entry_t            rdata_q;
  logic [IW-1:0]     raddr_q;
  logic              rwr_q;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              we;
  logic [IW-1:0]     waddr;
  entry_t            wdata;
  entry_t            rd_ent;

  // request registers
  opcode_e             op_q;
  logic [DeviceW-1:0]  dev_q;
  logic [BlockW-1:0]   blk_q;
  logic [BufIdxW-1:0]  idx_q;
  logic [BKW-1:0]      home_q;
  logic [CW-1:0]       cnt_q;
  logic [StampW-1:0]   ctr_q;

  // best match and best free entry found by the sweep
  logic              m_found_q;
  logic [IW-1:0]     m_idx_q;
  logic [StampW-1:0] m_stamp_q;
  logic [RefW-1:0]   m_ref_q;
  logic              m_valid_q;
  logic              f_found_q;
  logic [IW-1:0]     f_idx_q;
  logic [StampW-1:0] f_stamp_q;
  logic [BKW-1:0]    f_gap_q;

  // result register
  logic              out_v_q;
  logic [BufIdxW-1:0] out_idx_q;
  logic              out_hit_q;
  logic              out_read_q;
  status_e           out_st_q;

  logic              in_acc;
  logic              mod_start;
  logic              mod_done;
  logic [BKW-1:0]    mod_rem;
  logic              is_match;
  logic              is_free;
  logic [BKW-1:0]    bkt_gap;
  logic              idx_ok;
  logic              out_stall;

  // result computed in the update cycle
  logic [BufIdxW-1:0] r_idx;
  logic              r_hit;
  logic              r_read;
  status_e           r_st;
  logic              r_bump;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign mod_start       = in_acc && (opcode_e'(s_axis_tuser_i) == OP_GET);
  assign out_stall       = out_v_q && !m_axis_tready_i;
  assign idx_ok          = (32'(idx_q) < ENTRIES);

  hlbd_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (s_axis_tdata_i[63:32]),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  // read address: requested entry on accept, sweep counter otherwise
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_q[IW-1:0];
    if (in_acc) begin
      rd_en   = 1'b1;
      rd_addr = IW'(s_axis_tdata_i[68:64]);
    end else if (state_q == S_SCAN && cnt_q < CW'(ENTRIES)) begin
      rd_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
      raddr_q <= rd_addr;
      rwr_q   <= wr_q[rd_addr];
    end
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
    end else if (we) begin
      wr_q[waddr] <= 1'b1;
    end
  end

  // unwritten entries show their reset contents
  always_comb begin
    if (rwr_q) begin
      rd_ent = rdata_q;
    end else begin
      rd_ent       = '0;
      rd_ent.stamp = StampW'(raddr_q);
    end
  end

  // sweep compare: match and distance of a free entry from home
  always_comb begin
    is_match = (rd_ent.dev == dev_q) && (rd_ent.blk == blk_q) && (rd_ent.bucket == home_q);
    is_free  = (rd_ent.refcnt == '0);
    if (rd_ent.bucket >= home_q) begin
      bkt_gap = rd_ent.bucket - home_q;
    end else begin
      bkt_gap = BKW'((BKW+1)'(rd_ent.bucket) + (BKW+1)'(BUCKETS) - (BKW+1)'(home_q));
    end
  end

  // update cycle: result and write-back
  always_comb begin
    r_idx  = '0;
    r_hit  = 1'b0;
    r_read = 1'b0;
    r_st   = ST_OK;
    r_bump = 1'b0;
    we     = 1'b0;
    waddr  = m_idx_q;
    wdata  = rd_ent;
    if (state_q == S_UPD && !out_stall) begin
      if (op_q == OP_GET) begin
        if (m_found_q) begin
          r_idx = BufIdxW'(m_idx_q);
          r_hit = 1'b1;
          if (m_ref_q == '1) begin
            r_st = ST_REFUSED;
          end else begin
            r_read = !m_valid_q;
            we     = 1'b1;
            wdata  = '{stamp: m_stamp_q, bucket: home_q, valid: 1'b1,
                       refcnt: m_ref_q + 8'd1, blk: blk_q, dev: dev_q};
          end
        end else if (f_found_q) begin
          r_idx  = BufIdxW'(f_idx_q);
          r_read = 1'b1;
          r_bump = 1'b1;
          we     = 1'b1;
          waddr  = f_idx_q;
          wdata  = '{stamp: ctr_q, bucket: home_q, valid: 1'b1,
                     refcnt: 8'd1, blk: blk_q, dev: dev_q};
        end else begin
          r_st = ST_NOFREE;
        end
      end else begin
        r_idx = idx_q;
        waddr = IW'(idx_q);
        if (!idx_ok) begin
          r_st = ST_REFUSED;
        end else if (op_q == OP_PIN) begin
          if (rd_ent.refcnt == '1) begin
            r_st = ST_REFUSED;
          end else begin
            we           = 1'b1;
            wdata.refcnt = rd_ent.refcnt + 8'd1;
          end
        end else begin
          if (rd_ent.refcnt == '0) begin
            r_st = ST_REFUSED;
          end else begin
            we           = 1'b1;
            wdata.refcnt = rd_ent.refcnt - 8'd1;
            if (op_q == OP_RELEASE && rd_ent.refcnt == 8'd1) begin
              wdata.stamp = ctr_q;
              r_bump      = 1'b1;
            end
          end
        end
      end
    end
  end

  // control sequencer and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      ctr_q     <= StampW'(ENTRIES);
      m_found_q <= 1'b0;
      f_found_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      // result held while stalled, loaded when the update cycle completes
      out_v_q <= out_stall || (state_q == S_UPD);
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= mod_start ? S_MOD : S_UPD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state_q   <= S_SCAN;
            cnt_q     <= '0;
            m_found_q <= 1'b0;
            f_found_q <= 1'b0;
          end
        end
        S_SCAN: begin
          if (cnt_q != '0) begin
            if (is_match && (!m_found_q || rd_ent.stamp >= m_stamp_q)) begin
              m_found_q <= 1'b1;
            end
            if (is_free && (!f_found_q || bkt_gap < f_gap_q ||
                            (bkt_gap == f_gap_q && rd_ent.stamp < f_stamp_q))) begin
              f_found_q <= 1'b1;
            end
          end
          if (cnt_q == CW'(ENTRIES)) begin
            state_q <= S_UPD;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        S_UPD: begin
          if (!out_stall) begin
            state_q <= S_IDLE;
            if (r_bump) begin
              ctr_q <= ctr_q + StampW'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= opcode_e'(s_axis_tuser_i);
      dev_q <= s_axis_tdata_i[31:0];
      blk_q <= s_axis_tdata_i[63:32];
      idx_q <= s_axis_tdata_i[68:64];
    end
    if (state_q == S_MOD && mod_done) begin
      home_q <= mod_rem;
    end
    if (state_q == S_SCAN && cnt_q != '0) begin
      if (is_match && (!m_found_q || rd_ent.stamp >= m_stamp_q)) begin
        m_idx_q   <= raddr_q;
        m_stamp_q <= rd_ent.stamp;
        m_ref_q   <= rd_ent.refcnt;
        m_valid_q <= rd_ent.valid;
      end
      if (is_free && (!f_found_q || bkt_gap < f_gap_q ||
                      (bkt_gap == f_gap_q && rd_ent.stamp < f_stamp_q))) begin
        f_idx_q   <= raddr_q;
        f_stamp_q <= rd_ent.stamp;
        f_gap_q   <= bkt_gap;
      end
    end
    if (state_q == S_UPD && !out_stall) begin
      out_idx_q  <= r_idx;
      out_hit_q  <= r_hit;
      out_read_q <= r_read;
      out_st_q   <= r_st;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {7'd0, out_st_q, out_read_q, out_hit_q, out_idx_q};

  `ASSERT_IMPL(a_nofree_zero, m_axis_tvalid_o && out_st_q == ST_NOFREE,
               out_idx_q == '0 && !out_hit_q && !out_read_q, "no-free result not cleared")
  `ASSERT_IMPL(a_refused_hit, m_axis_tvalid_o && out_hit_q && out_st_q == ST_REFUSED,
               !out_read_q, "refused hit asks for a read")
  `ASSERT_CLK(a_rise_from_upd, $rose(m_axis_tvalid_o) |-> $past(state_q == S_UPD),
              "result appeared outside update")

endmodule

/* rtl/hlbd_mod.sv */
// remainder of a block number by the bucket count
`timescale 1ns / 1ps
module hlbd_mod import hlbd_pkg::*; #(
  parameter int BUCKETS = BucketsDef,
  localparam int BKW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [BlockW-1:0] value_i,
  output logic              done_o,
  output logic [BKW-1:0]    rem_o
);

  // reciprocal of the bucket count, rounded up, scaled by 2^(BlockW+SH)
  localparam int SH = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
  localparam int MW = BlockW + 1;
  localparam int PW = BlockW + MW;
  localparam logic [MW-1:0] Recip =
    MW'(((64'd1 << (BlockW + SH)) / 64'(BUCKETS)) + 64'd1);

  logic [PW-1:0]     prod_q, prod_d;
  logic [BlockW-1:0] val_q;
  logic              v_q;
  logic              done_q;
  logic [BKW-1:0]    rem_q, rem_d;
  logic [BlockW-1:0] quot;
  logic [BlockW-1:0] diff;

  // quotient by reciprocal multiply, remainder by multiply-back and subtract
  always_comb begin
    prod_d = PW'(value_i) * PW'(Recip);
    quot   = BlockW'(prod_q >> (BlockW + SH));
    diff   = val_q - BlockW'(quot * BlockW'(BUCKETS));
    rem_d  = BKW'(diff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= 1'b0;
      done_q <= 1'b0;
      rem_q  <= '0;
    end else begin
      v_q    <= start_i;
      done_q <= v_q;
      if (v_q) begin
        rem_q <= rem_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= prod_d;
      val_q  <= value_i;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* tb/sv/tb_hashed_lru_block_buffer_directory.sv */
// self-checking testbench of the hashed lru block buffer directory
`timescale 1ns / 1ps
module tb_hashed_lru_block_buffer_directory import hlbd_pkg::*; ();

  localparam int NumEnt = EntriesDef;
  localparam int NumBkt = BucketsDef;
  localparam int RandItems = 60;
  localparam longint CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // device [31:0], block_number [63:32], buffer_index [68:64], zero fill
  logic [71:0] s_axis_tdata_i = '0;
  // opcode [1:0]
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // entry_index [4:0], hit [5], needs_read [6], status [8:7], zero fill
  logic [15:0] m_axis_tdata_o;

  typedef struct packed {
    status_e    st;
    logic       rd;
    logic       hit;
    logic [4:0] idx;
  } lookup_t;

  typedef struct {
    opcode_e     op;
    logic [31:0] dev;
    logic [31:0] blk;
    logic [4:0]  bidx;
    logic        has_exp;
    lookup_t     exp;
  } req_t;

  hashed_lru_block_buffer_directory i_dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow directory
  logic [31:0] sh_dev [NumEnt];
  logic [31:0] sh_blk [NumEnt];
  logic [7:0]  sh_ref [NumEnt];
  logic        sh_val [NumEnt];
  logic [3:0]  sh_bkt [NumEnt];
  logic [31:0] sh_stamp [NumEnt];
  logic [31:0] sh_clock;

  lookup_t expected_q[$];
  int errors = 0;
  int n_sent = 0, n_got = 0, n_hit = 0, n_nofree = 0, n_refused = 0;
  int sink_wait = 0;
  longint cycles = 0;

  function automatic void dir_reset();
    for (int i = 0; i < NumEnt; i++) begin
      sh_dev[i] = '0; sh_blk[i] = '0; sh_ref[i] = '0; sh_val[i] = 1'b0;
      sh_bkt[i] = '0; sh_stamp[i] = i;
    end
    sh_clock = NumEnt;
  endfunction

  function automatic void touch(int e);
    sh_stamp[e] = sh_clock;
    sh_clock = sh_clock + 1;
  endfunction

  // compute the lookup result and update the shadow directory
  function automatic lookup_t dir_apply(opcode_e op, logic [31:0] dev, logic [31:0] blk,
                                        logic [4:0] bidx);
    lookup_t r;
    int home, best, b;
    bit found;
    r = '{idx: '0, hit: 1'b0, rd: 1'b0, st: ST_OK};
    found = 1'b0;
    best = 0;
    if (op == OP_GET) begin
      home = blk % NumBkt;
      for (int i = 0; i < NumEnt; i++)
        if (sh_bkt[i] == home && sh_dev[i] == dev && sh_blk[i] == blk)
          if (!found || sh_stamp[i] >= sh_stamp[best]) begin
            best = i; found = 1'b1;
          end
      if (found) begin
        r.idx = 5'(best); r.hit = 1'b1;
        if (sh_ref[best] == 8'hff) r.st = ST_REFUSED;
        else begin
          sh_ref[best]++;
          r.rd = !sh_val[best];
          sh_val[best] = 1'b1;
        end
      end else begin
        for (int k = 0; k < NumBkt && !found; k++) begin
          b = (home + k) % NumBkt;
          for (int i = 0; i < NumEnt; i++)
            if (sh_bkt[i] == b && sh_ref[i] == 0)
              if (!found || sh_stamp[i] < sh_stamp[best]) begin
                best = i; found = 1'b1;
              end
        end
        if (found) begin
          sh_dev[best] = dev; sh_blk[best] = blk; sh_ref[best] = 8'd1;
          sh_bkt[best] = 4'(home); sh_val[best] = 1'b1;
          touch(best);
          r.idx = 5'(best); r.rd = 1'b1;
        end else r.st = ST_NOFREE;
      end
    end else begin
      r.idx = bidx;
      if (bidx >= NumEnt) r.st = ST_REFUSED;
      else if (op == OP_PIN) begin
        if (sh_ref[bidx] == 8'hff) r.st = ST_REFUSED;
        else sh_ref[bidx]++;
      end else begin
        if (sh_ref[bidx] == 0) r.st = ST_REFUSED;
        else begin
          sh_ref[bidx]--;
          if (op == OP_RELEASE && sh_ref[bidx] == 0) touch(bidx);
        end
      end
    end
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // send one request and record the expected lookup result
  task automatic send_req(req_t q);
    lookup_t p;
    p = dir_apply(q.op, q.dev, q.blk, q.bidx);
    if (q.has_exp && p != q.exp) begin
      $display("%0t table row disagrees with predictor: table %h predictor %h",
               $time, q.exp, p);
      errors++;
    end
    expected_q.push_back(p);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= q.op;
    s_axis_tdata_i  <= {3'b0, q.bidx, q.blk, q.dev};
    do @(posedge clk_i); while (!s_axis_tready_o);
    n_sent++;
  endtask

  task automatic idle_src(int n);
    if (n == 0) return;
    s_axis_tvalid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // result checking and sink stalls
  always @(posedge clk_i) begin
    lookup_t act, exp;
    if (rst_ni) begin
      cycles++;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        act = m_axis_tdata_o[8:0];
        n_got++;
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result: actual %h", $time, act);
          errors++;
        end else begin
          exp = expected_q.pop_front();
          if (act.idx != exp.idx) begin
            $display("%0t entry_index: expected %0d actual %0d", $time, exp.idx, act.idx);
            errors++;
          end
          if (act.hit != exp.hit) begin
            $display("%0t hit: expected %0b actual %0b", $time, exp.hit, act.hit);
            errors++;
          end
          if (act.rd != exp.rd) begin
            $display("%0t needs_read: expected %0b actual %0b", $time, exp.rd, act.rd);
            errors++;
          end
          if (act.st != exp.st) begin
            $display("%0t status: expected %0d actual %0d", $time, exp.st, act.st);
            errors++;
          end
          if (exp.hit) n_hit++;
          if (exp.st == ST_NOFREE) n_nofree++;
          if (exp.st == ST_REFUSED) n_refused++;
        end
      end
      if (sink_wait > 0) begin
        m_axis_tready_i <= 1'b0;
        sink_wait--;
      end else begin
        m_axis_tready_i <= 1'b1;
        sink_wait = gap_len();
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("%0t run limit reached", $time);
      $display("[hashed_lru_block_buffer_directory] ERROR");
      $finish;
    end
  end

  function automatic req_t mk(opcode_e op, logic [31:0] dev, logic [31:0] blk,
                              logic [4:0] bidx);
    req_t q;
    q.op = op; q.dev = dev; q.blk = blk; q.bidx = bidx; q.has_exp = 1'b0;
    q.exp = '0;
    return q;
  endfunction

  function automatic req_t mkx(opcode_e op, logic [31:0] dev, logic [31:0] blk,
                               logic [4:0] bidx, lookup_t e);
    req_t q;
    q = mk(op, dev, blk, bidx);
    q.has_exp = 1'b1; q.exp = e;
    return q;
  endfunction

  initial begin
    req_t dir_tab[$];
    req_t q;
    int sel, tgt;
    logic [31:0] dev_pool [4];
    logic [31:0] blk_pool [8];

    dir_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: reset state, extremes and refusals
    // after reset every entry matches device 0 block 0, highest stamp wins
    dir_tab.push_back(mkx(OP_GET, 32'h0, 32'h0, 5'd0,
                          '{idx: 5'd31, hit: 1'b1, rd: 1'b1, st: ST_OK}));
    dir_tab.push_back(mkx(OP_GET, 32'h0, 32'h0, 5'd0,
                          '{idx: 5'd31, hit: 1'b1, rd: 1'b0, st: ST_OK}));
    // release on a zero count is refused
    dir_tab.push_back(mkx(OP_RELEASE, 32'h0, 32'h0, 5'd3,
                          '{idx: 5'd3, hit: 1'b0, rd: 1'b0, st: ST_REFUSED}));
    dir_tab.push_back(mkx(OP_UNPIN, 32'h0, 32'h0, 5'd0,
                          '{idx: 5'd0, hit: 1'b0, rd: 1'b0, st: ST_REFUSED}));
    // miss takes entry 0, the least recent free one
    dir_tab.push_back(mkx(OP_GET, 32'hffff_ffff, 32'hffff_ffff, 5'd0,
                          '{idx: 5'd0, hit: 1'b0, rd: 1'b1, st: ST_OK}));
    dir_tab.push_back(mk(OP_GET, 32'hffff_ffff, 32'hffff_ffff, 5'd0));
    dir_tab.push_back(mk(OP_PIN, 32'hffff_ffff, 32'h0, 5'd0));
    dir_tab.push_back(mk(OP_UNPIN, 32'h0, 32'hffff_ffff, 5'd0));
    dir_tab.push_back(mk(OP_RELEASE, 32'h0, 32'h0, 5'd0));
    dir_tab.push_back(mk(OP_RELEASE, 32'h0, 32'h0, 5'd0));
    dir_tab.push_back(mk(OP_RELEASE, 32'h0, 32'h0, 5'd31));
    dir_tab.push_back(mk(OP_GET, 32'h1234_5678, 32'd12, 5'd31));
    dir_tab.push_back(mk(OP_GET, 32'h1234_5678, 32'd25, 5'd17));
    dir_tab.push_back(mk(OP_GET, 32'h1234_5678, 32'd12, 5'd0));
    dir_tab.push_back(mk(OP_PIN, 32'h0, 32'h0, 5'd31));
    for (int i = 0; i < dir_tab.size(); i++) begin
      send_req(dir_tab[i]);
      idle_src(gap_len());
    end

    // pin one entry up to its count limit, then refuse pin and get hit
    for (int i = 0; i < 255; i++) send_req(mk(OP_PIN, 32'h0, 32'h0, 5'd31));
    send_req(mk(OP_GET, 32'h0, 32'h0, 5'd0));

    // fill all entries so later misses find no free entry
    for (int i = 0; i < NumEnt + 2; i++)
      send_req(mk(OP_GET, 32'hdead_0000 + i, 32'd1000 + i, 5'd0));
    for (int i = 0; i < NumEnt; i++) begin
      send_req(mk(OP_RELEASE, 32'h0, 32'h0, i[4:0]));
    end

    // random part, mostly gets and releases over a small pool of blocks
    for (int i = 0; i < 4; i++) dev_pool[i] = $urandom();
    for (int i = 0; i < 8; i++) blk_pool[i] = $urandom();
    for (int n = 0; n < RandItems; n++) begin
      sel = $urandom_range(0, 99);
      tgt = $urandom_range(0, NumEnt - 1);
      if (sel < 45)
        q = mk(OP_GET, dev_pool[$urandom_range(0, 3)],
               ($urandom_range(0, 3) == 0) ? $urandom() : blk_pool[$urandom_range(0, 7)],
               5'($urandom()));
      else if (sel < 75) q = mk(OP_RELEASE, $urandom(), $urandom(), 5'(tgt));
      else if (sel < 88) q = mk(OP_PIN, $urandom(), $urandom(), 5'(tgt));
      else q = mk(OP_UNPIN, $urandom(), $urandom(), 5'($urandom()));
      send_req(q);
      idle_src(gap_len());
    end
    s_axis_tvalid_i <= 1'b0;

    // drain and let the block settle
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    $display("sent %0d requests, got %0d results: %0d hits, %0d without free entry, %0d refused",
             n_sent, n_got, n_hit, n_nofree, n_refused);
    if (errors == 0) begin
      $display("[hashed_lru_block_buffer_directory] OK");
    end else begin
      $display("[hashed_lru_block_buffer_directory] ERROR");
    end
    $finish;
  end

endmodule
